// ===== sv/aavr_pkg.sv =====
// ---------------------------------------------------------------------------
// aavr_pkg
// Shared types, constants and the CORDIC arctangent table for the
// axis-angle vector rotation pipeline.
// ---------------------------------------------------------------------------
package aavr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  // steps beyond the table are dropped: STEPS is capped at the table size
  localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  // angle units of 2^-17 degree
  localparam logic [33:0] FULL_TURN    = 34'd47185920;
  localparam logic [33:0] NEG_OFFSET   = 34'd2170552320;  // 46 full turns
  localparam int          HALF_TURN    = 23592960;
  localparam int          QUARTER_TURN = 11796480;
  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;

  typedef logic signed [33:0] cxy_t;   // Q2.30 with headroom
  typedef logic signed [31:0] cz_t;    // 2^-22 degree
  typedef logic signed [27:0] quat_t;  // Q.24
  typedef logic signed [37:0] tvec_t;  // Q.16, first product

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } geom_t;

  function automatic cz_t atan_q22(input logic [4:0] idx);
    cz_t r;
    case (idx)
      5'd0:  r = 32'sd188743680;
      5'd1:  r = 32'sd111421900;
      5'd2:  r = 32'sd58872272;
      5'd3:  r = 32'sd29884485;
      5'd4:  r = 32'sd15000234;
      5'd5:  r = 32'sd7507429;
      5'd6:  r = 32'sd3754631;
      5'd7:  r = 32'sd1877430;
      5'd8:  r = 32'sd938729;
      5'd9:  r = 32'sd469366;
      5'd10: r = 32'sd234683;
      5'd11: r = 32'sd117342;
      5'd12: r = 32'sd58671;
      5'd13: r = 32'sd29335;
      5'd14: r = 32'sd14668;
      5'd15: r = 32'sd7334;
      5'd16: r = 32'sd3667;
      5'd17: r = 32'sd1833;
      5'd18: r = 32'sd917;
      5'd19: r = 32'sd458;
      5'd20: r = 32'sd229;
      5'd21: r = 32'sd115;
      5'd22: r = 32'sd57;
      5'd23: r = 32'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/aavr_reduce.sv =====
// ---------------------------------------------------------------------------
// aavr_reduce
// Three-stage half-angle reduction: modulo one turn by restoring
// subtraction, then fold into [-90, 90] degrees.
// ---------------------------------------------------------------------------
module aavr_reduce (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [31:0]   in_h,
  input  aavr_pkg::geom_t      in_geom,
  output logic                 out_vld,
  output aavr_pkg::cz_t        out_z,
  output logic                 out_flip,
  output aavr_pkg::geom_t      out_geom
);

  function automatic logic [33:0] sub_if(input logic [33:0] v, input logic [33:0] k);
    return (v >= k) ? (v - k) : v;
  endfunction

  logic [2:0]       vld_r;
  logic [33:0]      u1_r, u1_nxt, u2_r, u2_nxt;
  aavr_pkg::geom_t  g1_r, g2_r;
  aavr_pkg::cz_t    z_r, z_nxt;
  logic             flip_r, flip_nxt;
  aavr_pkg::geom_t  g3_r;
  logic [33:0]      u0;
  logic [33:0]      u3;
  logic signed [27:0] r0, r1;

  always_comb begin
    u0 = in_h[31] ? (34'(signed'(in_h)) + aavr_pkg::NEG_OFFSET) : 34'(in_h);
    u1_nxt = sub_if(sub_if(u0, aavr_pkg::FULL_TURN << 6), aavr_pkg::FULL_TURN << 5);
    u2_nxt = sub_if(sub_if(sub_if(u1_r, aavr_pkg::FULL_TURN << 4),
                           aavr_pkg::FULL_TURN << 3), aavr_pkg::FULL_TURN << 2);
    u3 = sub_if(sub_if(u2_r, aavr_pkg::FULL_TURN << 1), aavr_pkg::FULL_TURN);
    r0 = 28'(u3);
    if (r0 >= 28'(aavr_pkg::HALF_TURN)) r0 = r0 - 28'(aavr_pkg::FULL_TURN);
    flip_nxt = 1'b0;
    r1 = r0;
    if (r0 > 28'(aavr_pkg::QUARTER_TURN)) begin
      r1 = r0 - 28'(aavr_pkg::HALF_TURN);
      flip_nxt = 1'b1;
    end else if (r0 < -28'(aavr_pkg::QUARTER_TURN)) begin
      r1 = r0 + 28'(aavr_pkg::HALF_TURN);
      flip_nxt = 1'b1;
    end
    z_nxt = {r1[26:0], 5'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
    if (en) begin
      u1_r   <= u1_nxt;
      g1_r   <= in_geom;
      u2_r   <= u2_nxt;
      g2_r   <= g1_r;
      z_r    <= z_nxt;
      flip_r <= flip_nxt;
      g3_r   <= g2_r;
    end
  end

  assign out_vld  = vld_r[2];
  assign out_z    = z_r;
  assign out_flip = flip_r;
  assign out_geom = g3_r;

endmodule

// ===== sv/aavr_cordic.sv =====
// ---------------------------------------------------------------------------
// aavr_cordic
// Rotation-mode CORDIC, one register stage per step; sine in y, cosine in x.
// ---------------------------------------------------------------------------
module aavr_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  aavr_pkg::cz_t        in_z,
  input  logic                 in_flip,
  input  aavr_pkg::geom_t      in_geom,
  output logic                 out_vld,
  output aavr_pkg::cxy_t       out_sin,
  output aavr_pkg::cxy_t       out_cos,
  output logic                 out_flip,
  output aavr_pkg::geom_t      out_geom
);

  localparam int N = aavr_pkg::STEPS;

  logic            vld_s  [0:N];
  aavr_pkg::cxy_t  x_s    [0:N];
  aavr_pkg::cxy_t  y_s    [0:N];
  aavr_pkg::cz_t   z_s    [0:N];
  logic            flip_s [0:N];
  aavr_pkg::geom_t geom_s [0:N];

  assign vld_s[0]  = in_vld;
  assign x_s[0]    = aavr_pkg::INV_GAIN;
  assign y_s[0]    = '0;
  assign z_s[0]    = in_z;
  assign flip_s[0] = in_flip;
  assign geom_s[0] = in_geom;

  for (genvar i = 0; i < N; i++) begin : g_step
    aavr_pkg::cxy_t x_nxt, y_nxt;
    aavr_pkg::cz_t  z_nxt;
    logic           vld_r;
    aavr_pkg::cxy_t x_r, y_r;
    aavr_pkg::cz_t  z_r;
    logic           flip_r;
    aavr_pkg::geom_t geom_r;

    always_comb begin
      if (!z_s[i][31]) begin
        x_nxt = x_s[i] - (y_s[i] >>> i);
        y_nxt = y_s[i] + (x_s[i] >>> i);
        z_nxt = z_s[i] - aavr_pkg::atan_q22(5'(i));
      end else begin
        x_nxt = x_s[i] + (y_s[i] >>> i);
        y_nxt = y_s[i] - (x_s[i] >>> i);
        z_nxt = z_s[i] + aavr_pkg::atan_q22(5'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[i];
      end
      if (en) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        z_r    <= z_nxt;
        flip_r <= flip_s[i];
        geom_r <= geom_s[i];
      end
    end

    assign vld_s[i+1]  = vld_r;
    assign x_s[i+1]    = x_r;
    assign y_s[i+1]    = y_r;
    assign z_s[i+1]    = z_r;
    assign flip_s[i+1] = flip_r;
    assign geom_s[i+1] = geom_r;
  end

  assign out_vld  = vld_s[N];
  assign out_sin  = y_s[N];
  assign out_cos  = x_s[N];
  assign out_flip = flip_s[N];
  assign out_geom = geom_s[N];

endmodule

// ===== sv/aavr_rotate.sv =====
// ---------------------------------------------------------------------------
// aavr_rotate
// Quaternion build and the two quaternion products, six register stages;
// the last stage is the output register.
// ---------------------------------------------------------------------------
module aavr_rotate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  aavr_pkg::cxy_t       in_sin,
  input  aavr_pkg::cxy_t       in_cos,
  input  logic                 in_flip,
  input  aavr_pkg::geom_t      in_geom,
  output logic                 out_vld,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z
);

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [43:0] r;
    r = 44'((v + 68'sd8388608) >>> 24);
    if (r > 44'sd2147483647)       return 32'sh7fffffff;
    else if (r < -44'sd2147483648) return 32'sh80000000;
    else                           return r[31:0];
  endfunction

  logic [5:0] vld_r;

  // stage 1: axis times sine
  logic signed [49:0] pax_r, pay_r, paz_r;
  aavr_pkg::cxy_t     c1_r;
  aavr_pkg::geom_t    g1_r;
  aavr_pkg::cxy_t     s_sel, c_sel;

  // stage 2: quaternion, Q.24
  aavr_pkg::quat_t    qx_r, qy_r, qz_r, qw_r;
  aavr_pkg::geom_t    g2_r;

  // stage 3: q * v products
  logic signed [59:0] pv_r [0:11];
  aavr_pkg::quat_t    qx3_r, qy3_r, qz3_r, qw3_r;

  // stage 4: t, Q.16
  aavr_pkg::tvec_t    tw_r, tx_r, ty_r, tz_r;
  aavr_pkg::quat_t    qx4_r, qy4_r, qz4_r, qw4_r;
  aavr_pkg::tvec_t    tw_nxt, tx_nxt, ty_nxt, tz_nxt;

  // stage 5: t * conj(q) products
  logic signed [65:0] pt_r [0:11];

  // stage 6: output
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic signed [67:0] fx, fy, fz;

  always_comb begin
    s_sel = in_flip ? -in_sin : in_sin;
    c_sel = in_flip ? -in_cos : in_cos;

    tw_nxt = 38'((-62'(pv_r[0]) - 62'(pv_r[1]) - 62'(pv_r[2]) + 62'sd8388608) >>> 24);
    tx_nxt = 38'((62'(pv_r[3]) + 62'(pv_r[4]) - 62'(pv_r[5]) + 62'sd8388608) >>> 24);
    ty_nxt = 38'((62'(pv_r[6]) + 62'(pv_r[7]) - 62'(pv_r[8]) + 62'sd8388608) >>> 24);
    tz_nxt = 38'((62'(pv_r[9]) + 62'(pv_r[10]) - 62'(pv_r[11]) + 62'sd8388608) >>> 24);

    fx = 68'(pt_r[0]) - 68'(pt_r[1]) - 68'(pt_r[2]) + 68'(pt_r[3]);
    fy = 68'(pt_r[4]) - 68'(pt_r[5]) - 68'(pt_r[6]) + 68'(pt_r[7]);
    fz = 68'(pt_r[8]) - 68'(pt_r[9]) - 68'(pt_r[10]) + 68'(pt_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
    if (en) begin
      pax_r <= 50'(in_geom.ax) * 50'(s_sel);
      pay_r <= 50'(in_geom.ay) * 50'(s_sel);
      paz_r <= 50'(in_geom.az) * 50'(s_sel);
      c1_r  <= c_sel;
      g1_r  <= in_geom;

      qx_r <= 28'((pax_r + 50'sd524288) >>> 20);
      qy_r <= 28'((pay_r + 50'sd524288) >>> 20);
      qz_r <= 28'((paz_r + 50'sd524288) >>> 20);
      qw_r <= 28'((c1_r + 34'sd32) >>> 6);
      g2_r <= g1_r;

      pv_r[0]  <= 60'(qx_r) * 60'(g2_r.vx);
      pv_r[1]  <= 60'(qy_r) * 60'(g2_r.vy);
      pv_r[2]  <= 60'(qz_r) * 60'(g2_r.vz);
      pv_r[3]  <= 60'(qw_r) * 60'(g2_r.vx);
      pv_r[4]  <= 60'(qy_r) * 60'(g2_r.vz);
      pv_r[5]  <= 60'(qz_r) * 60'(g2_r.vy);
      pv_r[6]  <= 60'(qw_r) * 60'(g2_r.vy);
      pv_r[7]  <= 60'(qz_r) * 60'(g2_r.vx);
      pv_r[8]  <= 60'(qx_r) * 60'(g2_r.vz);
      pv_r[9]  <= 60'(qw_r) * 60'(g2_r.vz);
      pv_r[10] <= 60'(qx_r) * 60'(g2_r.vy);
      pv_r[11] <= 60'(qy_r) * 60'(g2_r.vx);
      qx3_r <= qx_r;
      qy3_r <= qy_r;
      qz3_r <= qz_r;
      qw3_r <= qw_r;

      tw_r  <= tw_nxt;
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
      tz_r  <= tz_nxt;
      qx4_r <= qx3_r;
      qy4_r <= qy3_r;
      qz4_r <= qz3_r;
      qw4_r <= qw3_r;

      // conj(q) signs folded into the final sums
      pt_r[0]  <= 66'(tx_r) * 66'(qw4_r);
      pt_r[1]  <= 66'(tw_r) * 66'(qx4_r);
      pt_r[2]  <= 66'(ty_r) * 66'(qz4_r);
      pt_r[3]  <= 66'(tz_r) * 66'(qy4_r);
      pt_r[4]  <= 66'(ty_r) * 66'(qw4_r);
      pt_r[5]  <= 66'(tw_r) * 66'(qy4_r);
      pt_r[6]  <= 66'(tz_r) * 66'(qx4_r);
      pt_r[7]  <= 66'(tx_r) * 66'(qz4_r);
      pt_r[8]  <= 66'(tz_r) * 66'(qw4_r);
      pt_r[9]  <= 66'(tw_r) * 66'(qz4_r);
      pt_r[10] <= 66'(tx_r) * 66'(qy4_r);
      pt_r[11] <= 66'(ty_r) * 66'(qx4_r);

      ox_r <= sat32(fx);
      oy_r <= sat32(fy);
      oz_r <= sat32(fz);
    end
  end

  assign out_vld = vld_r[5];
  assign out_x   = ox_r;
  assign out_y   = oy_r;
  assign out_z   = oz_r;

endmodule

// ===== sv/axis_angle_vector_rotation_top.sv =====
// ---------------------------------------------------------------------------
// axis_angle_vector_rotation_top
// Rotates a Q16.16 vector about a Q2.14 axis by an angle in degrees.
// ---------------------------------------------------------------------------
// Input channel in_*: angle (Q16.16 degrees, any value), axis and vector.
// A transaction completes when in_valid is high and in_stall is low.
// Output channel out_*: the rotated vector, saturated to 32 bits, one
// transaction out for every transaction in, in order.
// Throughput: one transaction per cycle while the pipeline is not held. The
// pipeline has three angle reduction stages, one stage per CORDIC step,
// and six stages of quaternion build and products.
// The whole pipeline advances together; it holds when the output register
// holds a result and out_stall is high, and in_stall is raised in that case.
// Bubbles move through like items, so a stall loses nothing.
// Reset (rst_n low, synchronous) clears every valid bit; no output
// transaction is offered until new input arrives.
// ---------------------------------------------------------------------------
module axis_angle_vector_rotation_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_angle_deg,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  logic            en;
  aavr_pkg::geom_t geom_in, geom_red, geom_cor;
  logic            vld_red, vld_cor, flip_red, flip_cor;
  aavr_pkg::cz_t   z_red;
  aavr_pkg::cxy_t  sin_cor, cos_cor;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign geom_in = '{ax: in_axis_x, ay: in_axis_y, az: in_axis_z,
                     vx: in_vec_x, vy: in_vec_y, vz: in_vec_z};

  aavr_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_h     (in_angle_deg),
    .in_geom  (geom_in),
    .out_vld  (vld_red),
    .out_z    (z_red),
    .out_flip (flip_red),
    .out_geom (geom_red)
  );

  aavr_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_red),
    .in_z     (z_red),
    .in_flip  (flip_red),
    .in_geom  (geom_red),
    .out_vld  (vld_cor),
    .out_sin  (sin_cor),
    .out_cos  (cos_cor),
    .out_flip (flip_cor),
    .out_geom (geom_cor)
  );

  aavr_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_cor),
    .in_sin  (sin_cor),
    .in_cos  (cos_cor),
    .in_flip (flip_cor),
    .in_geom (geom_cor),
    .out_vld (out_valid),
    .out_x   (out_x),
    .out_y   (out_y),
    .out_z   (out_z)
  );

endmodule

// ===== sv/aavr_checker.sv =====
// ---------------------------------------------------------------------------
// aavr_checker
// Port-level checks on the rotation pipeline, bound to the top level.
// ---------------------------------------------------------------------------
module aavr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
                               && $stable(out_z))
    else $error("held result changed");

  // input is only held back by a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // no result straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // a taken result frees the input side
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output flows");

endmodule

bind axis_angle_vector_rotation_top aavr_checker u_aavr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z)
);
